// ----- hdl/lpuq_pkg.sv -----
// Shared constants, payload types and controller/datapath command and status structs.
package lpuq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int TPS_W       = 8;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic take_sample;
    logic push_held;
    logic div_start;
    logic rd_head;
    logic init_cur;
    logic push_cur;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic held_valid;
    logic div_done;
    logic interp_more;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/lpuq_if.sv -----
// Valid/ready channel interfaces for events, popped positions and configuration.
interface lpuq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic signed [lpuq_pkg::COORD_W-1:0]  in_x;
  logic signed [lpuq_pkg::COORD_W-1:0]  in_y;
  logic signed [lpuq_pkg::COORD_W-1:0]  in_z;
  logic                                 last_of_snapshot;

  modport source (output valid, kind, in_x, in_y, in_z, last_of_snapshot, input ready);
  modport sink (input valid, kind, in_x, in_y, in_z, last_of_snapshot, output ready);
endinterface

interface lpuq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 pos_valid;
  logic signed [lpuq_pkg::COORD_W-1:0]  out_x;
  logic signed [lpuq_pkg::COORD_W-1:0]  out_y;
  logic signed [lpuq_pkg::COORD_W-1:0]  out_z;
  logic                                 overflowed;

  modport source (output valid, pos_valid, out_x, out_y, out_z, overflowed, input ready);
  modport sink (input valid, pos_valid, out_x, out_y, out_z, overflowed, output ready);
endinterface

interface lpuq_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpuq_pkg::TPS_W-1:0]       ticks_per_sample;

  modport source (output valid, ticks_per_sample, input ready);
  modport sink (input valid, ticks_per_sample, output ready);
endinterface

// ----- hdl/lpuq_div.sv -----
// Restoring divider, one quotient bit per cycle, signed dividend, truncating toward zero.
module lpuq_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [lpuq_pkg::DIFF_W-1:0] dividend,
  input  logic        [lpuq_pkg::TPS_W-1:0]  divisor,
  output logic                               done,
  output logic signed [lpuq_pkg::DIFF_W-1:0] quotient
);
  import lpuq_pkg::*;

  localparam int STEP_W = $clog2(DIFF_W);

  logic [DIFF_W-1:0] mag;
  logic [DIFF_W-1:0] dividend_u;
  logic [TPS_W-1:0]  rem;
  logic [TPS_W-1:0]  dvsr;
  logic              neg;
  logic              busy;
  logic [STEP_W-1:0] step;
  logic [TPS_W:0]    trial;
  logic [TPS_W:0]    trial_sub;
  logic              fits;

  assign dividend_u = dividend;
  assign trial      = {rem, mag[DIFF_W-1]};
  assign fits       = trial >= {1'b0, dvsr};
  assign trial_sub  = trial - {1'b0, dvsr};
  assign quotient   = neg ? $signed(~mag + DIFF_W'(1)) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIFF_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits into the low end as the dividend bits leave the top.
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DIFF_W-1];
      mag  <= dividend[DIFF_W-1] ? (~dividend_u + DIFF_W'(1)) : dividend_u;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      mag <= {mag[DIFF_W-2:0], fits};
      rem <= fits ? trial_sub[TPS_W-1:0] : trial[TPS_W-1:0];
    end
  end

endmodule

// ----- hdl/lpuq_ctrl.sv -----
// Sequencer: accepts events and steps the datapath through division, fill and pop.
module lpuq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_kind,
  output logic            in_ready,
  input  lpuq_pkg::stat_t stat,
  output lpuq_pkg::cmd_t  cmd
);
  import lpuq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_INTERP = 5'b00100,
    S_FINAL  = 5'b01000,
    S_TICK   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    accept     = in_valid && in_ready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_TICK) begin
            cmd.rd_head = 1'b1;
            state_next  = S_TICK;
          end else begin
            cmd.take_sample = 1'b1;
            if (stat.held_valid) begin
              // queue the earlier sample while the increment is divided out
              cmd.push_held = 1'b1;
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end else begin
              state_next = S_FINAL;
            end
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.init_cur = 1'b1;
          state_next   = S_INTERP;
        end
      end
      S_INTERP: begin
        if (stat.interp_more) begin
          cmd.push_cur = 1'b1;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK: begin
        // hold the popped entry until the output register frees up
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/lpuq_datapath.sv -----
// Datapath: held sample, per-axis dividers, point accumulator, position queue, output register.
module lpuq_datapath (
  input  logic            clk,
  input  logic            rst,
  input  lpuq_pkg::cmd_t  cmd,
  output lpuq_pkg::stat_t stat,
  input  lpuq_pkg::pos_t  smp,
  input  logic            smp_last,
  lpuq_cfg_if.sink        cfg,
  lpuq_out_if.source      positions
);
  import lpuq_pkg::*;

  pos_t               mem [QUEUE_DEPTH];
  pos_t               rd_data;
  pos_t               s_reg;
  pos_t               held;
  pos_t               inc;
  pos_t               cur;
  pos_t               wdata;
  logic               last_reg;
  logic               held_valid;
  logic [TPS_W-1:0]   tps;
  logic [TPS_W-1:0]   t_eff;
  logic [TPS_W-1:0]   t_reg;
  logic [TPS_W-1:0]   k;
  logic [QADDR_W-1:0] head;
  logic [QADDR_W-1:0] tail;
  logic [COUNT_W-1:0] count;
  logic               full;
  logic               push;
  logic               sticky;
  logic               out_valid;
  logic               out_free;
  logic               out_pos_valid;
  logic               out_ovf;
  pos_t               out_pos;

  logic signed [DIFF_W-1:0] diff_x, diff_y, diff_z;
  logic signed [DIFF_W-1:0] q_x, q_y, q_z;
  logic                     done_x, done_y, done_z;

  function automatic logic [QADDR_W-1:0] wrap_inc(input logic [QADDR_W-1:0] a);
    wrap_inc = (a == QADDR_W'(QUEUE_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  assign cfg.ready = 1'b1;
  assign t_eff     = (tps == '0) ? TPS_W'(1) : tps;

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (cfg.valid) begin
      tps <= cfg.ticks_per_sample;
    end
  end

  // Differences are one bit wider than the coordinates so the subtraction cannot overflow.
  assign diff_x = $signed({smp.x[COORD_W-1], smp.x}) - $signed({held.x[COORD_W-1], held.x});
  assign diff_y = $signed({smp.y[COORD_W-1], smp.y}) - $signed({held.y[COORD_W-1], held.y});
  assign diff_z = $signed({smp.z[COORD_W-1], smp.z}) - $signed({held.z[COORD_W-1], held.z});

  lpuq_div u_div_x (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(diff_x), .divisor(t_eff),
    .done(done_x), .quotient(q_x)
  );
  lpuq_div u_div_y (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(diff_y), .divisor(t_eff),
    .done(done_y), .quotient(q_y)
  );
  lpuq_div u_div_z (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(diff_z), .divisor(t_eff),
    .done(done_z), .quotient(q_z)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      s_reg    <= smp;
      last_reg <= smp_last;
      t_reg    <= t_eff;
    end
    if (cmd.finish && !last_reg) begin
      held <= s_reg;
    end
    // Points stay within the two samples, so 32-bit wrapping sums are exact.
    if (cmd.init_cur) begin
      inc.x <= q_x[COORD_W-1:0];
      inc.y <= q_y[COORD_W-1:0];
      inc.z <= q_z[COORD_W-1:0];
      cur.x <= held.x + q_x[COORD_W-1:0];
      cur.y <= held.y + q_y[COORD_W-1:0];
      cur.z <= held.z + q_z[COORD_W-1:0];
      k     <= TPS_W'(1);
    end else if (cmd.push_cur) begin
      cur.x <= cur.x + inc.x;
      cur.y <= cur.y + inc.y;
      cur.z <= cur.z + inc.z;
      k     <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (cmd.finish) begin
      held_valid <= !last_reg;
    end
  end

  assign push = cmd.push_held || cmd.push_cur || (cmd.finish && last_reg);
  assign full = (count == COUNT_W'(QUEUE_DEPTH));

  always_comb begin
    if (cmd.push_held) begin
      wdata = held;
    end else if (cmd.push_cur) begin
      wdata = cur;
    end else begin
      wdata = s_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[tail] <= wdata;
    end
    if (cmd.rd_head) begin
      rd_data <= mem[head];
    end
  end

  // Pushes and pops never fall in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      tail   <= '0;
      count  <= '0;
      sticky <= 1'b0;
    end else if (push) begin
      if (full) begin
        sticky <= 1'b1;
      end else begin
        tail  <= wrap_inc(tail);
        count <= count + 1'b1;
      end
    end else if (cmd.load_out) begin
      sticky <= 1'b0;
      if (count != '0) begin
        head  <= wrap_inc(head);
        count <= count - 1'b1;
      end
    end
  end

  assign out_free = !out_valid || positions.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (positions.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_pos_valid <= (count != '0);
      out_pos       <= (count != '0) ? rd_data : '0;
      out_ovf       <= sticky;
    end
  end

  assign positions.valid      = out_valid;
  assign positions.pos_valid  = out_pos_valid;
  assign positions.out_x      = out_pos.x;
  assign positions.out_y      = out_pos.y;
  assign positions.out_z      = out_pos.z;
  assign positions.overflowed = out_ovf;

  assign stat.held_valid  = held_valid;
  assign stat.div_done    = done_x && done_y && done_z;
  assign stat.interp_more = (k < t_reg);
  assign stat.out_free    = out_free;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("empty queue with head and tail apart");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("output register overwritten before it was taken");

  a_one_push: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_held, cmd.push_cur, cmd.finish && last_reg}))
    else $error("more than one queue write in a cycle");

  a_sticky_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> !sticky)
    else $error("drop flag survived a tick");

endmodule

// ----- hdl/linear_position_upsampler_queue.sv -----
// Top level: position upsampler with interpolation queue, controller plus datapath.
//
//   channel    dir  handshake     payload
//   events     in   valid/ready   kind, in_x, in_y, in_z, last_of_snapshot
//   positions  out  valid/ready   pos_valid, out_x, out_y, out_z, overflowed
//   cfg        in   valid/ready   ticks_per_sample (ready always high)
//
// A sample with no earlier sample open goes from idle to the final state. A
// sample joined to an earlier one runs the bit-serial dividers first,
// then one queue write per cycle through the single memory write port.
// A tick waits while the previous position is not taken.
// Reset (synchronous, active high) clears pointers, flags and the register; the
// queue memory is not cleared.
module linear_position_upsampler_queue (
  input  logic        clk,
  input  logic        rst,
  lpuq_in_if.sink     events,
  lpuq_out_if.source  positions,
  lpuq_cfg_if.sink    cfg
);
  import lpuq_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  pos_t  smp;
  logic  in_ready;

  assign smp.x        = events.in_x;
  assign smp.y        = events.in_y;
  assign smp.z        = events.in_z;
  assign events.ready = in_ready;

  lpuq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (events.valid),
    .in_kind  (events.kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lpuq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .smp       (smp),
    .smp_last  (events.last_of_snapshot),
    .cfg       (cfg),
    .positions (positions)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench for the position upsampler queue: self-checking scoreboard with random traffic.
module tb;
  import lpuq_pkg::*;

  localparam int  SETTLE_CYCLES = 320;
  localparam int  CYCLE_LIMIT   = 2000000;
  localparam int  NUM_PHASES    = 11;
  localparam logic signed [COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;

  typedef struct packed {
    logic                      pos_valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      overflowed;
  } tick_result_t;

  class position_scoreboard;
    pos_t             pos_fifo[$];
    pos_t             held;
    bit               held_valid;
    bit               drop_sticky;
    logic [TPS_W-1:0] tps;
    tick_result_t     pending[$];
    int               errors;

    function new();
      held        = '0;
      held_valid  = 0;
      drop_sticky = 0;
      tps         = TPS_RESET;
      errors      = 0;
    endfunction

    function void set_ticks(logic [TPS_W-1:0] v);
      tps = v;
    endfunction

    function void push_pos(pos_t p);
      if (pos_fifo.size() >= QUEUE_DEPTH) drop_sticky = 1;
      else pos_fifo.insert(pos_fifo.size(), p);
    endfunction

    // Predict the effect of one accepted item.
    function void note_event(kind_t k, pos_t s, logic last);
      longint       t;
      longint       inc[3];
      longint       cur[3];
      longint       h[3];
      longint       n[3];
      pos_t         p;
      tick_result_t r;
      if (k == KIND_SAMPLE) begin
        if (held_valid) begin
          t = (tps == 0) ? 1 : longint'(tps);
          push_pos(held);
          h[0] = longint'(held.x); h[1] = longint'(held.y); h[2] = longint'(held.z);
          n[0] = longint'(s.x);    n[1] = longint'(s.y);    n[2] = longint'(s.z);
          for (int i = 0; i < 3; i++) begin
            inc[i] = (n[i] - h[i]) / t;   // truncates toward zero
            cur[i] = h[i] + inc[i];
          end
          for (longint k2 = 1; k2 < t; k2++) begin
            p.x = cur[0][COORD_W-1:0];
            p.y = cur[1][COORD_W-1:0];
            p.z = cur[2][COORD_W-1:0];
            push_pos(p);
            for (int i = 0; i < 3; i++) cur[i] += inc[i];
          end
        end
        if (last) begin
          push_pos(s);
          held_valid = 0;
        end else begin
          held       = s;
          held_valid = 1;
        end
      end else begin
        r = '0;
        if (pos_fifo.size() > 0) begin
          p = pos_fifo[0];
          pos_fifo.delete(0);
          r.pos_valid = 1;
          r.x = p.x;
          r.y = p.y;
          r.z = p.z;
        end
        r.overflowed = drop_sticky;
        drop_sticky  = 0;
        pending.insert(pending.size(), r);
      end
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected position: v=%0b x=%h y=%h z=%h ovf=%0b",
                   got.pos_valid, got.x, got.y, got.z, got.overflowed);
        return;
      end
      want = pending[0];
      pending.delete(0);
      if (got.pos_valid !== want.pos_valid || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.overflowed !== want.overflowed) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp v=%0b x=%h y=%h z=%h ovf=%0b, got v=%0b x=%h y=%h z=%h ovf=%0b",
                   want.pos_valid, want.x, want.y, want.z, want.overflowed,
                   got.pos_valid, got.x, got.y, got.z, got.overflowed);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   stall_left = 0;
  bit   sink_stalls = 0;
  bit   src_gaps = 0;
  position_scoreboard sb;

  lpuq_in_if  ev_if ();
  lpuq_out_if pos_if ();
  lpuq_cfg_if cfg_if ();

  linear_position_upsampler_queue uut (
    .clk       (clk),
    .rst       (rst),
    .events    (ev_if),
    .positions (pos_if),
    .cfg       (cfg_if)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Position sink: random back-pressure and result check.
  always @(posedge clk) begin
    tick_result_t got;
    if (!rst && pos_if.valid === 1'b1 && pos_if.ready === 1'b1) begin
      got.pos_valid  = pos_if.pos_valid;
      got.x          = pos_if.out_x;
      got.y          = pos_if.out_y;
      got.z          = pos_if.out_z;
      got.overflowed = pos_if.overflowed;
      sb.check_result(got);
    end
    if (stall_left != 0) begin
      pos_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
      pos_if.ready <= 1'b0;
      stall_left   <= pick_gap();
    end else begin
      pos_if.ready <= 1'b1;
    end
  end

  task automatic send_event(kind_t k, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z, logic last);
    int   gap;
    pos_t s;
    gap = src_gaps ? pick_gap() : 0;
    s.x = x;
    s.y = y;
    s.z = z;
    if (gap != 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_if.valid            <= 1'b1;
    ev_if.kind             <= k;
    ev_if.in_x             <= x;
    ev_if.in_y             <= y;
    ev_if.in_z             <= z;
    ev_if.last_of_snapshot <= last;
    do @(posedge clk); while (ev_if.ready !== 1'b1);
    sb.note_event(k, s, last);
  endtask

  // Tick with junk in the ignored fields.
  task automatic send_tick();
    send_event(KIND_TICK, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_results();
    ev_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Samples produce no result, so also let the longest join finish.
  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ticks(logic [TPS_W-1:0] v);
    cfg_if.valid            <= 1'b1;
    cfg_if.ticks_per_sample <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.set_ticks(v);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] prev);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return prev + COORD_W'(int'($urandom_range(0, 8191)) - 4096);
    if (r < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  task automatic run_phase(logic [TPS_W-1:0] tps, int items);
    int   snap_left;
    int   sample_pct;
    logic last;
    pos_t prev;
    snap_left = 0;
    prev = '0;
    if (tps <= 1) sample_pct = 45;
    else if (tps <= 4) sample_pct = 35;
    else if (tps <= 20) sample_pct = 15;
    else sample_pct = 8;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2 && $urandom_range(0, 2) == 0) wait_results();
      if ($urandom_range(0, 99) < sample_pct) begin
        if (snap_left == 0) snap_left = $urandom_range(1, 5);
        last = (snap_left == 1);
        snap_left--;
        // break the snapshot framing now and then
        if ($urandom_range(0, 9) == 0) last = 1'($urandom_range(0, 1));
        prev.x = pick_coord(prev.x);
        prev.y = pick_coord(prev.y);
        prev.z = pick_coord(prev.z);
        send_event(KIND_SAMPLE, prev.x, prev.y, prev.z, last);
      end else begin
        send_tick();
      end
    end
  endtask

  int unsigned tps_lo [NUM_PHASES] = '{0, 1, 2, 3, 4, 7, 255, 128, 1, 16, 1};
  int unsigned tps_hi [NUM_PHASES] = '{0, 1, 2, 3, 20, 7, 255, 128, 255, 16, 8};
  int          n_items[NUM_PHASES] = '{150, 200, 200, 200, 200, 150, 60, 60, 100, 200, 200};

  initial begin
    rst                     <= 1'b1;
    ev_if.valid             <= 1'b0;
    ev_if.kind              <= KIND_SAMPLE;
    ev_if.in_x              <= '0;
    ev_if.in_y              <= '0;
    ev_if.in_z              <= '0;
    ev_if.last_of_snapshot  <= 1'b0;
    cfg_if.valid            <= 1'b0;
    cfg_if.ticks_per_sample <= TPS_RESET;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset value of the register: empty tick, extreme joins, no intermediate points.
    send_tick();
    send_event(KIND_SAMPLE, CMAX, CMIN, 0, 1'b0);
    send_event(KIND_SAMPLE, CMIN, CMAX, -1, 1'b0);
    send_event(KIND_SAMPLE, CMAX, 0, CMIN, 1'b1);
    repeat (4) send_tick();

    // Negative increments round toward zero; single-sample snapshot.
    wait_idle();
    write_ticks(TPS_W'(4));
    send_event(KIND_SAMPLE, -1000, 1000, 7, 1'b0);
    send_event(KIND_SAMPLE, 1003, -999, -7, 1'b1);
    send_event(KIND_TICK, -1, -1, -1, 1'b1);
    send_event(KIND_SAMPLE, 5, -5, 0, 1'b1);
    repeat (6) send_tick();

    // Widest span between extremes overflows the queue.
    wait_idle();
    write_ticks(TPS_W'(255));
    send_event(KIND_SAMPLE, CMIN, CMIN, CMIN, 1'b0);
    send_event(KIND_SAMPLE, CMAX, CMAX, CMAX, 1'b0);
    send_event(KIND_SAMPLE, 0, 0, 0, 1'b1);
    repeat (3) send_tick();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_ticks(TPS_W'($urandom_range(tps_lo[ph], tps_hi[ph])));
      sink_stalls = (ph % 3 != 0);
      src_gaps    = (ph % 4 != 1);
      run_phase(sb.tps, n_items[ph]);
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lpuq_pkg.sv
hdl/lpuq_if.sv
hdl/lpuq_div.sv
hdl/lpuq_ctrl.sv
hdl/lpuq_datapath.sv
hdl/linear_position_upsampler_queue.sv
tb/tb.sv
